/* hdl/cpu_register_alu_execute_unit_defines.svh */
// assertion macros for the cpu register alu execute unit checker
// expects signals named clk and rst_n in the scope of use
`ifndef CPU_REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH
`define CPU_REGISTER_ALU_EXECUTE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define CRA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cra check failed");

// next-cycle implication, disabled while in reset
`define CRA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cra check failed");

`endif

/* hdl/cra_pkg.sv */
// shared types and codes of the cpu register alu execute unit
// used by the front end, the back end, the top level and the checker
package cra_pkg;

  // operation codes of the input item
  localparam logic [5:0] ACT_LDA     = 6'd0;
  localparam logic [5:0] ACT_LDX     = 6'd1;
  localparam logic [5:0] ACT_LDY     = 6'd2;
  localparam logic [5:0] ACT_ADC     = 6'd3;
  localparam logic [5:0] ACT_SBC     = 6'd4;
  localparam logic [5:0] ACT_AND     = 6'd5;
  localparam logic [5:0] ACT_ORA     = 6'd6;
  localparam logic [5:0] ACT_EOR     = 6'd7;
  localparam logic [5:0] ACT_CMP     = 6'd8;
  localparam logic [5:0] ACT_CPX     = 6'd9;
  localparam logic [5:0] ACT_CPY     = 6'd10;
  localparam logic [5:0] ACT_BIT     = 6'd11;
  localparam logic [5:0] ACT_TAX     = 6'd12;
  localparam logic [5:0] ACT_TAY     = 6'd13;
  localparam logic [5:0] ACT_TSX     = 6'd14;
  localparam logic [5:0] ACT_TXA     = 6'd15;
  localparam logic [5:0] ACT_TXS     = 6'd16;
  localparam logic [5:0] ACT_TYA     = 6'd17;
  localparam logic [5:0] ACT_INX     = 6'd18;
  localparam logic [5:0] ACT_INY     = 6'd19;
  localparam logic [5:0] ACT_DEX     = 6'd20;
  localparam logic [5:0] ACT_DEY     = 6'd21;
  localparam logic [5:0] ACT_CLC     = 6'd22;
  localparam logic [5:0] ACT_SEC     = 6'd23;
  localparam logic [5:0] ACT_NOP     = 6'd24;
  localparam logic [5:0] ACT_ASL_A   = 6'd25;
  localparam logic [5:0] ACT_LSR_A   = 6'd26;
  localparam logic [5:0] ACT_ROL_A   = 6'd27;
  localparam logic [5:0] ACT_ROR_A   = 6'd28;
  localparam logic [5:0] ACT_ASL_M   = 6'd29;
  localparam logic [5:0] ACT_LSR_M   = 6'd30;
  localparam logic [5:0] ACT_ROL_M   = 6'd31;
  localparam logic [5:0] ACT_ROR_M   = 6'd32;
  localparam logic [5:0] ACT_INC_M   = 6'd33;
  localparam logic [5:0] ACT_DEC_M   = 6'd34;
  localparam logic [5:0] ACT_PHA     = 6'd35;
  localparam logic [5:0] ACT_PLA     = 6'd36;

  // left alu source
  localparam logic [2:0] SRC_OPND = 3'd0;
  localparam logic [2:0] SRC_A    = 3'd1;
  localparam logic [2:0] SRC_X    = 3'd2;
  localparam logic [2:0] SRC_Y    = 3'd3;
  localparam logic [2:0] SRC_S    = 3'd4;

  // alu functions
  localparam logic [3:0] ALU_NONE = 4'd0;
  localparam logic [3:0] ALU_PASS = 4'd1;
  localparam logic [3:0] ALU_ADC  = 4'd2;
  localparam logic [3:0] ALU_SBC  = 4'd3;
  localparam logic [3:0] ALU_AND  = 4'd4;
  localparam logic [3:0] ALU_ORA  = 4'd5;
  localparam logic [3:0] ALU_EOR  = 4'd6;
  localparam logic [3:0] ALU_CMP  = 4'd7;
  localparam logic [3:0] ALU_INC  = 4'd8;
  localparam logic [3:0] ALU_DEC  = 4'd9;
  localparam logic [3:0] ALU_ASL  = 4'd10;
  localparam logic [3:0] ALU_LSR  = 4'd11;
  localparam logic [3:0] ALU_ROL  = 4'd12;
  localparam logic [3:0] ALU_ROR  = 4'd13;
  localparam logic [3:0] ALU_CLC  = 4'd14;
  localparam logic [3:0] ALU_SEC  = 4'd15;

  // result destination
  localparam logic [2:0] DST_NONE = 3'd0;
  localparam logic [2:0] DST_A    = 3'd1;
  localparam logic [2:0] DST_X    = 3'd2;
  localparam logic [2:0] DST_Y    = 3'd3;
  localparam logic [2:0] DST_S    = 3'd4;
  localparam logic [2:0] DST_MEM  = 3'd5;

  // stack pointer action
  localparam logic [1:0] STK_NONE = 2'd0;
  localparam logic [1:0] STK_PUSH = 2'd1;
  localparam logic [1:0] STK_PULL = 2'd2;

  // memory write codes of the result
  localparam logic [1:0] MW_NONE  = 2'd0;
  localparam logic [1:0] MW_OPND  = 2'd1;
  localparam logic [1:0] MW_STACK = 2'd2;

  // stack pointer reset value and the stack page
  localparam logic [7:0] SP_RESET   = 8'hFF;
  localparam logic       STACK_PAGE = 1'b1;

  typedef struct packed {
    logic [5:0] action;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic [7:0] stack_ptr;
    logic       carry;
    logic       zero;
    logic       negative;
    logic [1:0] mem_write;
    logic [7:0] write_data;
    logic [8:0] stack_address;
  } out_item_t;

  // classified operation handed from front end to back end
  typedef struct packed {
    logic [2:0] src;
    logic [3:0] alu;
    logic [2:0] dst;
    logic       flag_we;
    logic [1:0] stk;
    logic [7:0] operand;
  } dec_op_t;

endpackage

/* hdl/cpu_register_alu_execute_unit.sv */
// Executes one 8-bit accumulator operation per transfer (6502-style subset:
// loads, transfers, adc/sbc, logic ops, compares, bit, inc/dec, shifts and
// rotates, push/pull of A; no overflow flag, no decimal mode). Sustained rate
// is one item per clock cycle while a stalled receiver does not hold the
// result queue full, set by the execute step in the back end, whose register
// update feeds the next item directly. A result passes through the two-entry
// decode queue and is registered into the two-entry result queue, where it
// waits until popped. With the result side stalled, four items fit in flight
// before full rises.
// top level: front end cra_front, back end cra_back; types from cra_pkg
module cpu_register_alu_execute_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  cra_pkg::in_item_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output cra_pkg::out_item_t out_data
);

  logic             op_valid;
  logic             op_take;
  cra_pkg::dec_op_t op_data;

  // accept and classify
  cra_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .op_valid (op_valid),
    .op_take  (op_take),
    .op_data  (op_data)
  );

  // execute and queue results
  cra_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (op_valid),
    .op_take   (op_take),
    .op_data   (op_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

/* hdl/cra_front.sv */
// front end: accepts input items, classifies each operation and
// holds the classified ops in a two-entry queue; uses cra_pkg
module cra_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  cra_pkg::in_item_t  in_data,
  output logic               op_valid,
  input  logic               op_take,
  output cra_pkg::dec_op_t   op_data
);

  cra_pkg::dec_op_t dec;
  cra_pkg::dec_op_t q_mem [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_go, pop_go;

  // classify the operation code
  always_comb begin
    dec.src     = cra_pkg::SRC_OPND;
    dec.alu     = cra_pkg::ALU_NONE;
    dec.dst     = cra_pkg::DST_NONE;
    dec.flag_we = 1'b0;
    dec.stk     = cra_pkg::STK_NONE;
    dec.operand = in_data.operand;
    case (in_data.action)
      cra_pkg::ACT_LDA: begin
        dec.alu = cra_pkg::ALU_PASS; dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_LDX: begin
        dec.alu = cra_pkg::ALU_PASS; dec.dst = cra_pkg::DST_X; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_LDY: begin
        dec.alu = cra_pkg::ALU_PASS; dec.dst = cra_pkg::DST_Y; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_ADC: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_ADC;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_SBC: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_SBC;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_AND: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_AND;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_ORA: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_ORA;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_EOR: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_EOR;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_CMP: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_CMP; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_CPX: begin
        dec.src = cra_pkg::SRC_X; dec.alu = cra_pkg::ALU_CMP; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_CPY: begin
        dec.src = cra_pkg::SRC_Y; dec.alu = cra_pkg::ALU_CMP; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_BIT: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_AND; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_TAX: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_PASS;
        dec.dst = cra_pkg::DST_X; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_TAY: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_PASS;
        dec.dst = cra_pkg::DST_Y; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_TSX: begin
        dec.src = cra_pkg::SRC_S; dec.alu = cra_pkg::ALU_PASS;
        dec.dst = cra_pkg::DST_X; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_TXA: begin
        dec.src = cra_pkg::SRC_X; dec.alu = cra_pkg::ALU_PASS;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_TXS: begin
        // stack pointer load leaves the flag byte alone
        dec.src = cra_pkg::SRC_X; dec.alu = cra_pkg::ALU_PASS; dec.dst = cra_pkg::DST_S;
      end
      cra_pkg::ACT_TYA: begin
        dec.src = cra_pkg::SRC_Y; dec.alu = cra_pkg::ALU_PASS;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_INX: begin
        dec.src = cra_pkg::SRC_X; dec.alu = cra_pkg::ALU_INC;
        dec.dst = cra_pkg::DST_X; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_INY: begin
        dec.src = cra_pkg::SRC_Y; dec.alu = cra_pkg::ALU_INC;
        dec.dst = cra_pkg::DST_Y; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_DEX: begin
        dec.src = cra_pkg::SRC_X; dec.alu = cra_pkg::ALU_DEC;
        dec.dst = cra_pkg::DST_X; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_DEY: begin
        dec.src = cra_pkg::SRC_Y; dec.alu = cra_pkg::ALU_DEC;
        dec.dst = cra_pkg::DST_Y; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_CLC: dec.alu = cra_pkg::ALU_CLC;
      cra_pkg::ACT_SEC: dec.alu = cra_pkg::ALU_SEC;
      cra_pkg::ACT_NOP: dec.alu = cra_pkg::ALU_NONE;
      cra_pkg::ACT_ASL_A: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_ASL;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_LSR_A: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_LSR;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_ROL_A: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_ROL;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_ROR_A: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_ROR;
        dec.dst = cra_pkg::DST_A; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_ASL_M: begin
        dec.alu = cra_pkg::ALU_ASL; dec.dst = cra_pkg::DST_MEM; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_LSR_M: begin
        dec.alu = cra_pkg::ALU_LSR; dec.dst = cra_pkg::DST_MEM; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_ROL_M: begin
        dec.alu = cra_pkg::ALU_ROL; dec.dst = cra_pkg::DST_MEM; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_ROR_M: begin
        dec.alu = cra_pkg::ALU_ROR; dec.dst = cra_pkg::DST_MEM; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_INC_M: begin
        dec.alu = cra_pkg::ALU_INC; dec.dst = cra_pkg::DST_MEM; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_DEC_M: begin
        dec.alu = cra_pkg::ALU_DEC; dec.dst = cra_pkg::DST_MEM; dec.flag_we = 1'b1;
      end
      cra_pkg::ACT_PHA: begin
        dec.src = cra_pkg::SRC_A; dec.alu = cra_pkg::ALU_PASS; dec.stk = cra_pkg::STK_PUSH;
      end
      cra_pkg::ACT_PLA: begin
        dec.alu = cra_pkg::ALU_PASS; dec.dst = cra_pkg::DST_A;
        dec.flag_we = 1'b1; dec.stk = cra_pkg::STK_PULL;
      end
      default: dec.alu = cra_pkg::ALU_NONE;  // unused codes do nothing
    endcase
  end

  // queue handshake
  assign in_full  = (cnt_r == 2'd2);
  assign op_valid = (cnt_r != 2'd0);
  assign push_go  = in_push && !in_full;
  assign pop_go   = op_take && op_valid;
  assign op_data  = q_mem[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_go;
    rd_ptr_nxt = rd_ptr_r ^ pop_go;
    cnt_nxt    = cnt_r;
    if (push_go && !pop_go) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_go && !push_go) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push_go) begin
      q_mem[wr_ptr_r] <= dec;
    end
  end

endmodule

/* hdl/cra_back.sv */
// back end: executes classified ops on the register file and
// queues result items in a two-entry output queue; uses cra_pkg
module cra_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  output logic               op_take,
  input  cra_pkg::dec_op_t   op_data,
  output logic               out_empty,
  input  logic               out_pop,
  output cra_pkg::out_item_t out_data
);

  logic [7:0] acc_r, acc_nxt;
  logic [7:0] x_r, x_nxt;
  logic [7:0] y_r, y_nxt;
  logic [7:0] sp_r, sp_nxt;
  logic       carry_r, carry_nxt;
  logic [7:0] flag_r, flag_nxt;

  logic [7:0] opa, addb, res;
  logic       add_cin;
  logic [8:0] sum;
  cra_pkg::out_item_t rslt;

  cra_pkg::out_item_t r_mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       exec_go, res_pop;

  // left operand select
  always_comb begin
    case (op_data.src)
      cra_pkg::SRC_A:    opa = acc_r;
      cra_pkg::SRC_X:    opa = x_r;
      cra_pkg::SRC_Y:    opa = y_r;
      cra_pkg::SRC_S:    opa = sp_r;
      default:           opa = op_data.operand;
    endcase
  end

  // shared adder for add, subtract, compare, increment and decrement
  always_comb begin
    addb    = op_data.operand;
    add_cin = carry_r;
    case (op_data.alu)
      cra_pkg::ALU_SBC: addb = ~op_data.operand;
      cra_pkg::ALU_CMP: begin addb = ~op_data.operand; add_cin = 1'b1; end
      cra_pkg::ALU_INC: begin addb = 8'h00; add_cin = 1'b1; end
      cra_pkg::ALU_DEC: begin addb = 8'hFF; add_cin = 1'b0; end
      default: ;
    endcase
    sum = {1'b0, opa} + {1'b0, addb} + {8'h00, add_cin};
  end

  // alu result and carry
  always_comb begin
    res       = opa;
    carry_nxt = carry_r;
    case (op_data.alu)
      cra_pkg::ALU_ADC, cra_pkg::ALU_SBC, cra_pkg::ALU_CMP: begin
        res = sum[7:0]; carry_nxt = sum[8];
      end
      cra_pkg::ALU_INC, cra_pkg::ALU_DEC: res = sum[7:0];
      cra_pkg::ALU_AND: res = opa & op_data.operand;
      cra_pkg::ALU_ORA: res = opa | op_data.operand;
      cra_pkg::ALU_EOR: res = opa ^ op_data.operand;
      cra_pkg::ALU_ASL: begin res = {opa[6:0], 1'b0};    carry_nxt = opa[7]; end
      cra_pkg::ALU_LSR: begin res = {1'b0, opa[7:1]};    carry_nxt = opa[0]; end
      cra_pkg::ALU_ROL: begin res = {opa[6:0], carry_r}; carry_nxt = opa[7]; end
      cra_pkg::ALU_ROR: begin res = {carry_r, opa[7:1]}; carry_nxt = opa[0]; end
      cra_pkg::ALU_CLC: carry_nxt = 1'b0;
      cra_pkg::ALU_SEC: carry_nxt = 1'b1;
      default: res = opa;
    endcase
  end

  // register write back and result item
  always_comb begin
    acc_nxt  = acc_r;
    x_nxt    = x_r;
    y_nxt    = y_r;
    sp_nxt   = sp_r;
    flag_nxt = op_data.flag_we ? res : flag_r;
    case (op_data.dst)
      cra_pkg::DST_A: acc_nxt = res;
      cra_pkg::DST_X: x_nxt   = res;
      cra_pkg::DST_Y: y_nxt   = res;
      cra_pkg::DST_S: sp_nxt  = res;
      default: ;
    endcase
    case (op_data.stk)
      cra_pkg::STK_PUSH: sp_nxt = sp_r - 8'd1;
      cra_pkg::STK_PULL: sp_nxt = sp_r + 8'd1;
      default: ;
    endcase

    rslt.acc           = acc_nxt;
    rslt.index_x       = x_nxt;
    rslt.index_y       = y_nxt;
    rslt.stack_ptr     = sp_nxt;
    rslt.carry         = carry_nxt;
    rslt.zero          = (flag_nxt == 8'h00);
    rslt.negative      = flag_nxt[7];
    rslt.mem_write     = cra_pkg::MW_NONE;
    rslt.write_data    = 8'h00;
    rslt.stack_address = 9'h000;
    if (op_data.dst == cra_pkg::DST_MEM) begin
      rslt.mem_write  = cra_pkg::MW_OPND;
      rslt.write_data = res;
    end else if (op_data.stk == cra_pkg::STK_PUSH) begin
      rslt.mem_write     = cra_pkg::MW_STACK;
      rslt.write_data    = res;
      rslt.stack_address = {cra_pkg::STACK_PAGE, sp_r};
    end
  end

  // execute when an op waits and the output queue has room
  assign out_empty = (cnt_r == 2'd0);
  assign res_pop   = out_pop && !out_empty;
  assign op_take   = (cnt_r != 2'd2) || res_pop;
  assign exec_go   = op_valid && op_take;
  assign out_data  = r_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= 8'h00;
      x_r     <= 8'h00;
      y_r     <= 8'h00;
      sp_r    <= cra_pkg::SP_RESET;
      carry_r <= 1'b0;
      flag_r  <= 8'h00;
    end else if (exec_go) begin
      acc_r   <= acc_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      sp_r    <= sp_nxt;
      carry_r <= carry_nxt;
      flag_r  <= flag_nxt;
    end
  end

  // output queue fill count
  always_comb begin
    cnt_nxt = cnt_r;
    if (exec_go && !res_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (res_pop && !exec_go) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_r ^ exec_go;
      rd_ptr_r <= rd_ptr_r ^ res_pop;
      cnt_r    <= cnt_nxt;
    end
  end

  // output queue storage
  always_ff @(posedge clk) begin
    if (exec_go) begin
      r_mem[wr_ptr_r] <= rslt;
    end
  end

endmodule

/* hdl/cra_checker.sv */
// port-level checks of the cpu register alu execute unit, bound to the top
// depends on cra_pkg and cpu_register_alu_execute_unit_defines.svh
`include "cpu_register_alu_execute_unit_defines.svh"

module cra_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input cra_pkg::out_item_t out_data
);

  // a waiting result holds until its transfer
  `CRA_ASSERT_NXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_data))

  // no write means write data and stack address are quiet
  `CRA_ASSERT_IMP(a_quiet_nowrite, !out_empty && out_data.mem_write == cra_pkg::MW_NONE, out_data.write_data == 8'h00 && out_data.stack_address == 9'h000)

  // a push writes page one at the old stack pointer, one above the new one
  `CRA_ASSERT_IMP(a_push_addr, !out_empty && out_data.mem_write == cra_pkg::MW_STACK, out_data.stack_address[8] && out_data.stack_ptr == out_data.stack_address[7:0] - 8'd1)

  // zero and negative come from one flag byte
  `CRA_ASSERT_IMP(a_flag_excl, !out_empty, !(out_data.zero && out_data.negative))

endmodule

bind cpu_register_alu_execute_unit cra_checker u_cra_checker (.*);

/* tb/cra_result_check.sv */
// result checker for the cpu register alu execute unit: keeps its own copy of
// the register file, predicts each result and compares every out_ transfer
// depends on cra_pkg for the item types and operation codes
module cra_result_check (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  cra_pkg::in_item_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  cra_pkg::out_item_t out_data,
  output int                 error_count,
  output int                 pending
);

  // predicted architectural state
  logic [7:0] acc_q;
  logic [7:0] x_q;
  logic [7:0] y_q;
  logic [7:0] sp_q;
  logic       carry_q;
  logic [7:0] flag_q;

  cra_pkg::out_item_t expected_results[$];
  cra_pkg::out_item_t want;
  int         errs = 0;
  string      field_names[10] = '{"acc", "index_x", "index_y", "stack_ptr", "carry",
                                  "zero", "negative", "mem_write", "write_data",
                                  "stack_address"};

  // compare sets carry on no borrow, flags from the difference
  function automatic void compare_reg(logic [7:0] lhs, logic [7:0] rhs);
    carry_q = (lhs >= rhs);
    flag_q  = lhs - rhs;
  endfunction

  // shift or rotate by accumulator opcode, updates carry and flags
  function automatic logic [7:0] shift_byte(logic [5:0] op, logic [7:0] v);
    logic [7:0] r;
    case (op)
      cra_pkg::ACT_ASL_A: begin r = {v[6:0], 1'b0};    carry_q = v[7]; end
      cra_pkg::ACT_LSR_A: begin r = {1'b0, v[7:1]};    carry_q = v[0]; end
      cra_pkg::ACT_ROL_A: begin r = {v[6:0], carry_q}; carry_q = v[7]; end
      default:            begin r = {carry_q, v[7:1]}; carry_q = v[0]; end
    endcase
    flag_q = r;
    return r;
  endfunction

  // execute one operation on the predicted state and build its result
  function automatic cra_pkg::out_item_t execute_op(cra_pkg::in_item_t it);
    logic [8:0] sum;
    cra_pkg::out_item_t r;
    r = '0;
    case (it.action)
      cra_pkg::ACT_LDA: begin acc_q = it.operand; flag_q = acc_q; end
      cra_pkg::ACT_LDX: begin x_q = it.operand;   flag_q = x_q;   end
      cra_pkg::ACT_LDY: begin y_q = it.operand;   flag_q = y_q;   end
      cra_pkg::ACT_ADC: begin
        sum     = {1'b0, acc_q} + {1'b0, it.operand} + {8'h00, carry_q};
        carry_q = sum[8];
        acc_q   = sum[7:0];
        flag_q  = acc_q;
      end
      cra_pkg::ACT_SBC: begin
        sum     = {1'b0, acc_q} + {1'b0, ~it.operand} + {8'h00, carry_q};
        carry_q = sum[8];
        acc_q   = sum[7:0];
        flag_q  = acc_q;
      end
      cra_pkg::ACT_AND: begin acc_q = acc_q & it.operand; flag_q = acc_q; end
      cra_pkg::ACT_ORA: begin acc_q = acc_q | it.operand; flag_q = acc_q; end
      cra_pkg::ACT_EOR: begin acc_q = acc_q ^ it.operand; flag_q = acc_q; end
      cra_pkg::ACT_CMP: compare_reg(acc_q, it.operand);
      cra_pkg::ACT_CPX: compare_reg(x_q, it.operand);
      cra_pkg::ACT_CPY: compare_reg(y_q, it.operand);
      cra_pkg::ACT_BIT: flag_q = acc_q & it.operand;
      cra_pkg::ACT_TAX: begin x_q = acc_q; flag_q = x_q; end
      cra_pkg::ACT_TAY: begin y_q = acc_q; flag_q = y_q; end
      cra_pkg::ACT_TSX: begin x_q = sp_q;  flag_q = x_q; end
      cra_pkg::ACT_TXA: begin acc_q = x_q; flag_q = acc_q; end
      cra_pkg::ACT_TXS: sp_q = x_q;
      cra_pkg::ACT_TYA: begin acc_q = y_q; flag_q = acc_q; end
      cra_pkg::ACT_INX: begin x_q = x_q + 8'd1; flag_q = x_q; end
      cra_pkg::ACT_INY: begin y_q = y_q + 8'd1; flag_q = y_q; end
      cra_pkg::ACT_DEX: begin x_q = x_q - 8'd1; flag_q = x_q; end
      cra_pkg::ACT_DEY: begin y_q = y_q - 8'd1; flag_q = y_q; end
      cra_pkg::ACT_CLC: carry_q = 1'b0;
      cra_pkg::ACT_SEC: carry_q = 1'b1;
      cra_pkg::ACT_ASL_A, cra_pkg::ACT_LSR_A, cra_pkg::ACT_ROL_A, cra_pkg::ACT_ROR_A:
        acc_q = shift_byte(it.action, acc_q);
      cra_pkg::ACT_ASL_M, cra_pkg::ACT_LSR_M, cra_pkg::ACT_ROL_M, cra_pkg::ACT_ROR_M: begin
        r.write_data = shift_byte(it.action - (cra_pkg::ACT_ASL_M - cra_pkg::ACT_ASL_A),
                                  it.operand);
        r.mem_write  = cra_pkg::MW_OPND;
      end
      cra_pkg::ACT_INC_M: begin
        r.write_data = it.operand + 8'd1;
        flag_q       = r.write_data;
        r.mem_write  = cra_pkg::MW_OPND;
      end
      cra_pkg::ACT_DEC_M: begin
        r.write_data = it.operand - 8'd1;
        flag_q       = r.write_data;
        r.mem_write  = cra_pkg::MW_OPND;
      end
      cra_pkg::ACT_PHA: begin
        r.mem_write     = cra_pkg::MW_STACK;
        r.write_data    = acc_q;
        r.stack_address = {cra_pkg::STACK_PAGE, sp_q};
        sp_q            = sp_q - 8'd1;
      end
      cra_pkg::ACT_PLA: begin
        sp_q   = sp_q + 8'd1;
        acc_q  = it.operand;
        flag_q = acc_q;
      end
      // nop and every unused code leave the state alone
      default: ;
    endcase
    r.acc       = acc_q;
    r.index_x   = x_q;
    r.index_y   = y_q;
    r.stack_ptr = sp_q;
    r.carry     = carry_q;
    r.zero      = (flag_q == 8'h00);
    r.negative  = flag_q[7];
    return r;
  endfunction

  function automatic logic [8:0] field_of(cra_pkg::out_item_t r, int idx);
    case (idx)
      0: return {1'b0, r.acc};
      1: return {1'b0, r.index_x};
      2: return {1'b0, r.index_y};
      3: return {1'b0, r.stack_ptr};
      4: return {8'h00, r.carry};
      5: return {8'h00, r.zero};
      6: return {8'h00, r.negative};
      7: return {7'h00, r.mem_write};
      8: return {1'b0, r.write_data};
      default: return r.stack_address;
    endcase
  endfunction

  // watch both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      acc_q   = 8'h00;
      x_q     = 8'h00;
      y_q     = 8'h00;
      sp_q    = cra_pkg::SP_RESET;
      carry_q = 1'b0;
      flag_q  = 8'h00;
      expected_results.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          if (errs < 10)
            $display("%0t: result with nothing expected, acc %h stack_ptr %h", $realtime,
                     out_data.acc, out_data.stack_ptr);
          errs++;
        end else begin
          want = expected_results.pop_front();
          for (int i = 0; i < 10; i++) begin
            if (field_of(out_data, i) !== field_of(want, i)) begin
              if (errs < 10)
                $display("%0t: %s mismatch, expected %h got %h", $realtime,
                         field_names[i], field_of(want, i), field_of(out_data, i));
              errs++;
            end
          end
        end
      end
      // input transfer: predict its result
      if (in_push && !in_full)
        expected_results.push_back(execute_op(in_data));
    end
    pending     <= expected_results.size();
    error_count <= errs;
  end

endmodule

/* tb/cpu_register_alu_execute_unit_tb.sv */
// testbench top for the cpu register alu execute unit: drives operations with
// random gaps and pops, the checker predicts and compares every result
// depends on cra_pkg, cpu_register_alu_execute_unit and cra_result_check
module cpu_register_alu_execute_unit_tb;

  localparam logic [5:0] ACT_UNUSED_LOW = 6'd37;
  localparam logic [5:0] ACT_UNUSED_TOP = 6'h3F;
  localparam int         QUIET_LIMIT    = 5000;

  logic               clk;
  logic               rst_n   = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  cra_pkg::in_item_t  in_data = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  cra_pkg::out_item_t out_data;

  int        error_count;
  int        pending;
  int        send_gap_pct = 7;
  int        recv_gap_pct = 65;
  int        quiet_cycles = 0;

  cpu_register_alu_execute_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  cra_result_check result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_data     (in_data),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_data    (out_data),
    .error_count (error_count),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stalls at random
  always @(negedge clk) begin
    out_pop <= ($urandom_range(99) >= recv_gap_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_op(logic [5:0] act, logic [7:0] opnd);
    bit taken;
    while ($urandom_range(99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{action: act, operand: opnd};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !in_full;
      @(negedge clk);
    end
  endtask

  // mostly valid opcodes, operands leaning toward the byte extremes
  task automatic run_random(int count);
    logic [5:0] act;
    logic [7:0] opnd;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0)
        act = 6'($urandom_range(ACT_UNUSED_TOP));
      else
        act = 6'($urandom_range(cra_pkg::ACT_PLA));
      case ($urandom_range(9))
        0:       opnd = 8'h00;
        1:       opnd = 8'hFF;
        2:       opnd = 8'h80;
        3:       opnd = 8'h7F;
        default: opnd = 8'($urandom_range(255));
      endcase
      send_op(act, opnd);
    end
  endtask

  // hold off the sender until every predicted result has been popped
  task automatic wait_for_drain();
    in_push <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: flag extremes, carry and borrow, compares, stack wrap
    send_op(cra_pkg::ACT_LDA, 8'h00);
    send_op(cra_pkg::ACT_LDA, 8'h80);
    send_op(cra_pkg::ACT_ADC, 8'hFF);
    send_op(cra_pkg::ACT_ADC, 8'h00);
    send_op(cra_pkg::ACT_SBC, 8'h01);
    send_op(cra_pkg::ACT_SBC, 8'hFF);
    send_op(cra_pkg::ACT_CMP, 8'h7F);
    send_op(cra_pkg::ACT_LDX, 8'hFF);
    send_op(cra_pkg::ACT_CPX, 8'h00);
    send_op(cra_pkg::ACT_LDY, 8'h00);
    send_op(cra_pkg::ACT_CPY, 8'h01);
    send_op(cra_pkg::ACT_BIT, 8'h80);
    send_op(cra_pkg::ACT_LDX, 8'h00);
    send_op(cra_pkg::ACT_TXS, 8'h33);
    send_op(cra_pkg::ACT_PHA, 8'h00);
    send_op(cra_pkg::ACT_PLA, 8'hFF);
    send_op(cra_pkg::ACT_TSX, 8'h00);
    send_op(cra_pkg::ACT_DEX, 8'h00);
    send_op(cra_pkg::ACT_SEC, 8'h00);
    send_op(cra_pkg::ACT_ROR_A, 8'h00);
    send_op(cra_pkg::ACT_ROL_M, 8'hFF);
    send_op(cra_pkg::ACT_INC_M, 8'hFF);
    send_op(cra_pkg::ACT_DEC_M, 8'h00);
    send_op(ACT_UNUSED_LOW, 8'h5A);
    send_op(ACT_UNUSED_TOP, 8'hA5);

    run_random(625);
    wait_for_drain();

    send_gap_pct = 65;
    recv_gap_pct = 7;
    run_random(650);
    wait_for_drain();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_random(650);
    wait_for_drain();

    // let any stray result show up
    repeat (6) @(negedge clk);
    if (error_count == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
